>>> src/bis_pkg.sv
`default_nettype none
package bis_pkg;

  localparam int ROW_W   = 12;
  localparam int SCALE_W = 20;
  localparam int POS_W   = ROW_W + SCALE_W;
  localparam int DIM_W   = 9;
  localparam int SIZE_W  = 13;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int PIX_W   = CHAN_W * NCHAN;
  localparam int NBANK   = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SCALE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_COL = 3'd3;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic       req;
    logic       we;
    logic [1:0] wbank;
    logic       rpar;
    logic       cpar;
  } bis_ctl_t;

endpackage
`default_nettype wire

>>> src/bis_bank.sv
`default_nettype none
module bis_bank #(
  parameter int AW = 14
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [bis_pkg::PIX_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [bis_pkg::PIX_W-1:0] rdata
);

  logic [bis_pkg::PIX_W-1:0] mem [0:(1<<AW)-1];
  logic [bis_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/bis_map.sv
`default_nettype none
module bis_map #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 12,
  parameter int AW        = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic                          in_kind,
  input  wire logic [bis_pkg::ROW_W-1:0]     in_row,
  input  wire logic [bis_pkg::ROW_W-1:0]     in_col,
  input  wire logic [bis_pkg::PIX_W-1:0]     in_pix,
  input  wire logic [bis_pkg::SIZE_W-1:0]    rows_eff,
  input  wire logic [bis_pkg::SIZE_W-1:0]    cols_eff,
  input  wire logic [bis_pkg::SCALE_W-1:0]   inv_row,
  input  wire logic [bis_pkg::SCALE_W-1:0]   inv_col,
  output bis_pkg::bis_ctl_t                  ctl,
  output logic      [bis_pkg::ROW_W-1:0]     row_o,
  output logic      [bis_pkg::ROW_W-1:0]     col_o,
  output logic      [bis_pkg::PIX_W-1:0]     pix_o,
  output logic      [FRAC_BITS:0]            p_o,
  output logic      [FRAC_BITS:0]            q_o,
  output logic      [AW-1:0]                 waddr_o,
  output logic      [bis_pkg::NBANK-1:0][AW-1:0] raddr_o
);

  localparam int RB  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CB  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int RHB = (RB > 1) ? RB - 1 : 1;
  localparam int CHB = (CB > 1) ? CB - 1 : 1;
  localparam int PW  = bis_pkg::POS_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 1: coordinate times reciprocal scale
  logic                        v1_r, kind1_r;
  logic [bis_pkg::ROW_W-1:0]   row1_r, col1_r;
  logic [bis_pkg::PIX_W-1:0]   pix1_r;
  logic [PW-1:0]               posr1_r, posc1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    kind1_r <= in_kind;
    row1_r  <= in_row;
    col1_r  <= in_col;
    pix1_r  <= in_pix;
    posr1_r <= PW'(in_row) * PW'(inv_row);
    posc1_r <= PW'(in_col) * PW'(inv_col);
  end

  // stage 2: index clamp, fraction, bank addresses
  logic [PW-1:0]   ir_full, ic_full;
  logic            rclamp, cclamp;
  logic [RB-1:0]   ir, ir1, rsel;
  logic [CB-1:0]   ic, ic1, csel;
  logic [FRAC_BITS:0] p_nxt, q_nxt;
  logic [bis_pkg::NBANK-1:0][AW-1:0] raddr_nxt;
  logic [AW-1:0]   waddr_nxt;
  bis_pkg::bis_ctl_t ctl_nxt, ctl_r;

  always_comb begin
    ir_full = posr1_r >> FRAC_BITS;
    ic_full = posc1_r >> FRAC_BITS;
    rclamp  = ir_full >= (PW'(rows_eff) - PW'(1));
    cclamp  = ic_full >= (PW'(cols_eff) - PW'(1));
    ir      = rclamp ? RB'(rows_eff - bis_pkg::SIZE_W'(2)) : RB'(ir_full);
    ic      = cclamp ? CB'(cols_eff - bis_pkg::SIZE_W'(2)) : CB'(ic_full);
    ir1     = ir + RB'(1);
    ic1     = ic + CB'(1);
    p_nxt   = rclamp ? ONE : {1'b0, posr1_r[FRAC_BITS-1:0]};
    q_nxt   = cclamp ? ONE : {1'b0, posc1_r[FRAC_BITS-1:0]};
    rsel    = ir;
    csel    = ic;
    for (int k = 0; k < bis_pkg::NBANK; k++) begin
      rsel = (ir[0] == k[1]) ? ir : ir1;
      csel = (ic[0] == k[0]) ? ic : ic1;
      raddr_nxt[k] = {RHB'(rsel >> 1), CHB'(csel >> 1)};
    end
    waddr_nxt     = {RHB'(row1_r >> 1), CHB'(col1_r >> 1)};
    ctl_nxt.req   = v1_r && (kind1_r == bis_pkg::KIND_REQUEST);
    ctl_nxt.we    = v1_r && (kind1_r == bis_pkg::KIND_WRITE)
                    && (row1_r < bis_pkg::ROW_W'(MAX_ROWS))
                    && (col1_r < bis_pkg::ROW_W'(MAX_COLS));
    ctl_nxt.wbank = {row1_r[0], col1_r[0]};
    ctl_nxt.rpar  = ir[0];
    ctl_nxt.cpar  = ic[0];
  end

  logic [bis_pkg::ROW_W-1:0] row2_r, col2_r;
  logic [bis_pkg::PIX_W-1:0] pix2_r;
  logic [FRAC_BITS:0]        p2_r, q2_r;
  logic [AW-1:0]             waddr2_r;
  logic [bis_pkg::NBANK-1:0][AW-1:0] raddr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    row2_r   <= row1_r;
    col2_r   <= col1_r;
    pix2_r   <= pix1_r;
    p2_r     <= p_nxt;
    q2_r     <= q_nxt;
    waddr2_r <= waddr_nxt;
    raddr2_r <= raddr_nxt;
  end

  assign ctl     = ctl_r;
  assign row_o   = row2_r;
  assign col_o   = col2_r;
  assign pix_o   = pix2_r;
  assign p_o     = p2_r;
  assign q_o     = q2_r;
  assign waddr_o = waddr2_r;
  assign raddr_o = raddr2_r;

endmodule
`default_nettype wire

>>> src/bis_blend.sv
`default_nettype none
module bis_blend #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      req,
  input  wire logic [FRAC_BITS:0]        p,
  input  wire logic [FRAC_BITS:0]        q,
  input  wire logic [bis_pkg::ROW_W-1:0] row,
  input  wire logic [bis_pkg::ROW_W-1:0] col,
  input  wire logic [bis_pkg::PIX_W-1:0] pa,
  input  wire logic [bis_pkg::PIX_W-1:0] pb,
  input  wire logic [bis_pkg::PIX_W-1:0] pd,
  input  wire logic [bis_pkg::PIX_W-1:0] pe,
  output logic                           out_valid,
  output logic      [bis_pkg::ROW_W-1:0] out_row,
  output logic      [bis_pkg::ROW_W-1:0] out_col,
  output logic      [bis_pkg::PIX_W-1:0] out_pix
);

  localparam int FW = FRAC_BITS + bis_pkg::CHAN_W;
  localparam int MW = FRAC_BITS + 1 + FW;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // horizontal blend
  logic [bis_pkg::NCHAN-1:0][FW-1:0] f1_nxt, f2_nxt, f1_r, f2_r;
  logic [FRAC_BITS:0] omq;
  logic               v4_r;
  logic [FRAC_BITS:0] p4_r;
  logic [bis_pkg::ROW_W-1:0] row4_r, col4_r;

  always_comb begin
    omq = ONE - q;
    for (int k = 0; k < bis_pkg::NCHAN; k++) begin
      f1_nxt[k] = FW'(FW'(omq) * FW'(pa[8*k +: 8]) + FW'(q) * FW'(pb[8*k +: 8]));
      f2_nxt[k] = FW'(FW'(omq) * FW'(pd[8*k +: 8]) + FW'(q) * FW'(pe[8*k +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= req;
    end
    f1_r   <= f1_nxt;
    f2_r   <= f2_nxt;
    p4_r   <= p;
    row4_r <= row;
    col4_r <= col;
  end

  // vertical blend and truncation
  logic [FRAC_BITS:0] omp;
  logic [MW-1:0]      sum;
  logic [bis_pkg::PIX_W-1:0] pix_nxt, pix_r;
  logic               valid_r;
  logic [bis_pkg::ROW_W-1:0] row_r, col_r;

  always_comb begin
    omp     = ONE - p4_r;
    sum     = '0;
    pix_nxt = '0;
    for (int k = 0; k < bis_pkg::NCHAN; k++) begin
      sum = MW'(omp) * MW'(f1_r[k]) + MW'(p4_r) * MW'(f2_r[k]);
      pix_nxt[8*k +: 8] = sum[2*FRAC_BITS +: bis_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v4_r;
    end
    pix_r <= pix_nxt;
    row_r <= row4_r;
    col_r <= col4_r;
  end

  assign out_valid = valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_pix   = pix_r;

endmodule
`default_nettype wire

>>> src/bilinear_image_scaler.sv
// Bilinear image scaler. Holds a three-channel source image in four banks split
// by row and column parity, so the 2x2 neighborhood of a request is read from the
// four banks together. Takes one item per clock (busy never rises); a request
// produces its out_valid strobe after the map, bank-read and blend registers, a
// pixel write produces none. Writes and reads go through the same pipeline stage,
// so a request sees every write issued before it. Results cannot be stalled.
// Configuration may be written only while no item is in flight.
`default_nettype none
module bilinear_image_scaler #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_kind,
  input  wire logic [bis_pkg::ROW_W-1:0]        in_row,
  input  wire logic [bis_pkg::ROW_W-1:0]        in_col,
  input  wire logic [bis_pkg::CHAN_W-1:0]       in_chan0,
  input  wire logic [bis_pkg::CHAN_W-1:0]       in_chan1,
  input  wire logic [bis_pkg::CHAN_W-1:0]       in_chan2,
  output logic                                  out_valid,
  output logic      [bis_pkg::ROW_W-1:0]        out_row,
  output logic      [bis_pkg::ROW_W-1:0]        out_col,
  output logic      [bis_pkg::CHAN_W-1:0]       out_chan0,
  output logic      [bis_pkg::CHAN_W-1:0]       out_chan1,
  output logic      [bis_pkg::CHAN_W-1:0]       out_chan2,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RB  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CB  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int RHB = (RB > 1) ? RB - 1 : 1;
  localparam int CHB = (CB > 1) ? CB - 1 : 1;
  localparam int AW  = RHB + CHB;

  // configuration registers
  logic [bis_pkg::DIM_W-1:0]   rows_r, cols_r;
  logic [bis_pkg::SCALE_W-1:0] inv_row_r, inv_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= bis_pkg::DIM_W'(256);
      cols_r    <= bis_pkg::DIM_W'(256);
      inv_row_r <= bis_pkg::SCALE_W'(4096);
      inv_col_r <= bis_pkg::SCALE_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bis_pkg::CFG_ROWS:    rows_r    <= cfg_data[bis_pkg::DIM_W-1:0];
        bis_pkg::CFG_COLS:    cols_r    <= cfg_data[bis_pkg::DIM_W-1:0];
        bis_pkg::CFG_INV_ROW: inv_row_r <= cfg_data;
        bis_pkg::CFG_INV_COL: inv_col_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  logic [bis_pkg::SIZE_W-1:0] rows_eff, cols_eff;

  always_comb begin
    rows_eff = bis_pkg::SIZE_W'(rows_r);
    if (rows_eff < bis_pkg::SIZE_W'(2)) rows_eff = bis_pkg::SIZE_W'(2);
    if (rows_eff > bis_pkg::SIZE_W'(MAX_ROWS)) rows_eff = bis_pkg::SIZE_W'(MAX_ROWS);
    cols_eff = bis_pkg::SIZE_W'(cols_r);
    if (cols_eff < bis_pkg::SIZE_W'(2)) cols_eff = bis_pkg::SIZE_W'(2);
    if (cols_eff > bis_pkg::SIZE_W'(MAX_COLS)) cols_eff = bis_pkg::SIZE_W'(MAX_COLS);
  end

  // address mapping
  bis_pkg::bis_ctl_t             ctl2;
  logic [bis_pkg::ROW_W-1:0]     row2, col2;
  logic [bis_pkg::PIX_W-1:0]     pix2;
  logic [FRAC_BITS:0]            p2, q2;
  logic [AW-1:0]                 waddr2;
  logic [bis_pkg::NBANK-1:0][AW-1:0] raddr2;

  bis_map #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_kind  (in_kind),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_pix   ({in_chan2, in_chan1, in_chan0}),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .inv_row  (inv_row_r),
    .inv_col  (inv_col_r),
    .ctl      (ctl2),
    .row_o    (row2),
    .col_o    (col2),
    .pix_o    (pix2),
    .p_o      (p2),
    .q_o      (q2),
    .waddr_o  (waddr2),
    .raddr_o  (raddr2)
  );

  // parity banks
  logic [bis_pkg::NBANK-1:0][bis_pkg::PIX_W-1:0] rd;

  for (genvar k = 0; k < bis_pkg::NBANK; k++) begin : g_bank
    bis_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (ctl2.we && (ctl2.wbank == 2'(k))),
      .waddr (waddr2),
      .wdata (pix2),
      .raddr (raddr2[k]),
      .rdata (rd[k])
    );
  end

  bis_pkg::bis_ctl_t         ctl3_r;
  logic [bis_pkg::ROW_W-1:0] row3_r, col3_r;
  logic [FRAC_BITS:0]        p3_r, q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl2;
    end
    row3_r <= row2;
    col3_r <= col2;
    p3_r   <= p2;
    q3_r   <= q2;
  end

  logic [1:0] ba, bb, bd, be;

  always_comb begin
    ba = {ctl3_r.rpar, ctl3_r.cpar};
    bb = {ctl3_r.rpar, ~ctl3_r.cpar};
    bd = {~ctl3_r.rpar, ctl3_r.cpar};
    be = {~ctl3_r.rpar, ~ctl3_r.cpar};
  end

  logic [bis_pkg::PIX_W-1:0] out_pix;

  bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ctl3_r.req),
    .p         (p3_r),
    .q         (q3_r),
    .row       (row3_r),
    .col       (col3_r),
    .pa        (rd[ba]),
    .pb        (rd[bb]),
    .pd        (rd[bd]),
    .pe        (rd[be]),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_pix   (out_pix)
  );

  assign out_chan0 = out_pix[7:0];
  assign out_chan1 = out_pix[15:8];
  assign out_chan2 = out_pix[23:16];

endmodule
`default_nettype wire
